// File: sv/nvqrb_pkg.sv
`timescale 1ns / 1ps
package nvqrb_pkg;
   localparam logic [2:0] CMD_READ    = 3'd0;
   localparam logic [2:0] CMD_WRITE   = 3'd1;
   localparam logic [2:0] CMD_CONSUME = 3'd2;
   localparam logic [2:0] CMD_POST    = 3'd3;
   localparam logic [2:0] CMD_CREATE  = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_QID  = 3'd1;
   localparam logic [2:0] ST_NOT_RDY  = 3'd2;
   localparam logic [2:0] ST_BM_OFF   = 3'd3;
   localparam logic [2:0] ST_NO_BASE  = 3'd4;
   localparam logic [2:0] ST_EMPTY    = 3'd5;
   localparam logic [2:0] ST_REFUSED  = 3'd6;

   localparam logic [13:0] OFF_CAPL = 14'h00;
   localparam logic [13:0] OFF_CAPH = 14'h04;
   localparam logic [13:0] OFF_VS   = 14'h08;
   localparam logic [13:0] OFF_CC   = 14'h14;
   localparam logic [13:0] OFF_CSTS = 14'h1C;
   localparam logic [13:0] OFF_AQA  = 14'h24;
   localparam logic [13:0] OFF_ASQL = 14'h28;
   localparam logic [13:0] OFF_ASQH = 14'h2C;
   localparam logic [13:0] OFF_ACQL = 14'h30;
   localparam logic [13:0] OFF_ACQH = 14'h34;
   localparam logic [13:0] OFF_DB   = 14'h1000;

   localparam logic [31:0] VS_VALUE  = 32'h0001_0400;
   localparam logic [31:0] CAPH_VAL  = 32'h0000_0020;
   localparam logic [7:0]  CAP_TO    = 8'h14;

   typedef struct packed {
      logic [2:0]  command;
      logic [13:0] offset;
      logic [31:0] write_data;
      logic [15:0] queue_id;
      logic        is_completion;
      logic [15:0] size_minus_one;
      logic [63:0] queue_base;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [2:0]  status;
      logic [11:0] slot_index;
      logic [63:0] entry_address;
      logic        phase;
      logic [11:0] new_head;
   } rsp_type;
endpackage

// File: sv/nvme_queue_register_block_unit.sv
`timescale 1ns / 1ps
// NVMe register and queue-pointer block. One item in, one result out. An item
// is decoded and applied against the register and queue state in the cycle it
// is accepted, and its result is held in an output register: an item can be
// accepted every cycle while that register is empty or being drained. Each
// result is valid in the next cycle. Clearing CC.EN resets all queues at once.
module nvme_queue_register_block_unit #(
   parameter int NUM_QUEUES  = 2,
   parameter int MAX_ENTRIES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  nvqrb_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output nvqrb_pkg::rsp_type   rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_data
);
   import nvqrb_pkg::*;

   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam logic [12:0] MAXE = 13'(MAX_ENTRIES);

   logic bm_ff;
   logic [31:0] cc_ff, aqa_ff;
   logic rdy_ff;
   logic [63:0] asq_ff, acq_ff;
   logic [11:0] stail_ff [NUM_QUEUES];
   logic [11:0] shead_ff [NUM_QUEUES];
   logic [11:0] chead_ff [NUM_QUEUES];
   logic [11:0] ctail_ff [NUM_QUEUES];
   logic        cph_ff   [NUM_QUEUES];
   logic [12:0] ssize_ff [NUM_QUEUES];
   logic [12:0] csize_ff [NUM_QUEUES];
   logic [63:0] isb_ff   [NUM_QUEUES];
   logic [63:0] icb_ff   [NUM_QUEUES];
   logic rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic acc;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign acc = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   function automatic logic [12:0] clamp(input logic [16:0] n);
      return (n > 17'(MAX_ENTRIES)) ? MAXE : n[12:0];
   endfunction

   // decode
   logic qok;
   logic [QW-1:0] q;
   logic [13:0] dboff;
   logic [QW-1:0] dbq;
   logic db_hit, db_cq;
   logic [11:0] db_idx;
   logic [63:0] sb, cbase;
   logic [11:0] h_nx, t_nx;
   logic wrap;
   logic [2:0] chk;
   logic db_bad;

   always_comb begin
      qok = {16'd0, req_data.queue_id} < 32'(NUM_QUEUES);
      q = req_data.queue_id[QW-1:0];
      if (!qok) q = '0;
      dboff = req_data.offset - OFF_DB;
      db_idx = dboff[13:2];
      db_cq = db_idx[0];
      db_hit = req_data.offset >= OFF_DB && dboff[1:0] == 2'b00
               && {21'd0, db_idx[11:1]} < 32'(NUM_QUEUES);
      dbq = db_idx[QW:1];
      if (!db_hit) dbq = '0;
      db_bad = {1'b0, req_data.write_data} >=
               {20'd0, (db_cq ? csize_ff[dbq] : ssize_ff[dbq])};
      sb = (q == '0) ? asq_ff : isb_ff[q];
      cbase = (q == '0) ? acq_ff : icb_ff[q];
      priority if (!qok) chk = ST_BAD_QID;
      else if (!rdy_ff) chk = ST_NOT_RDY;
      else if (!bm_ff) chk = ST_BM_OFF;
      else if (sb == '0 || cbase == '0) chk = ST_NO_BASE;
      else chk = ST_OK;
      h_nx = ({1'b0, shead_ff[q]} + 13'd1 >= ssize_ff[q]) ? 12'd0 : shead_ff[q] + 12'd1;
      wrap = {1'b0, ctail_ff[q]} + 13'd1 >= csize_ff[q];
      t_nx = wrap ? 12'd0 : ctail_ff[q] + 12'd1;
   end

   always_comb begin
      rsp_in = '0;
      unique case (req_data.command)
         CMD_READ: begin
            unique case (req_data.offset)
               OFF_CAPL: rsp_in.read_data = {CAP_TO, 7'd0, 1'b1, 16'(MAX_ENTRIES - 1)};
               OFF_CAPH: rsp_in.read_data = CAPH_VAL;
               OFF_VS:   rsp_in.read_data = VS_VALUE;
               OFF_CC:   rsp_in.read_data = cc_ff;
               OFF_CSTS: rsp_in.read_data = {31'd0, rdy_ff};
               OFF_AQA:  rsp_in.read_data = aqa_ff;
               OFF_ASQL: rsp_in.read_data = asq_ff[31:0];
               OFF_ASQH: rsp_in.read_data = asq_ff[63:32];
               OFF_ACQL: rsp_in.read_data = acq_ff[31:0];
               OFF_ACQH: rsp_in.read_data = acq_ff[63:32];
               default:  rsp_in.read_data = '0;
            endcase
         end
         CMD_WRITE: begin
            if (db_hit && db_bad) rsp_in.status = ST_REFUSED;
         end
         CMD_CONSUME: begin
            if (chk != ST_OK) rsp_in.status = chk;
            else if (shead_ff[q] == stail_ff[q]) rsp_in.status = ST_EMPTY;
            else begin
               rsp_in.slot_index = shead_ff[q];
               rsp_in.entry_address = sb + {46'd0, shead_ff[q], 6'd0};
               rsp_in.new_head = h_nx;
            end
         end
         CMD_POST: begin
            if (chk != ST_OK) rsp_in.status = chk;
            else begin
               rsp_in.slot_index = ctail_ff[q];
               rsp_in.entry_address = cbase + {48'd0, ctail_ff[q], 4'd0};
               rsp_in.phase = cph_ff[q];
               rsp_in.new_head = shead_ff[q];
            end
         end
         CMD_CREATE: begin
            if (!qok || q == '0) rsp_in.status = ST_BAD_QID;
         end
         default: rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         bm_ff <= 1'b1;
      end else begin
         if (acc) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_valid) bm_ff <= csr_data;
      end
      if (acc) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (acc && req_data.command == CMD_WRITE && req_data.offset == OFF_CC
                    && !req_data.write_data[0])) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            stail_ff[i] <= '0; shead_ff[i] <= '0; chead_ff[i] <= '0;
            ctail_ff[i] <= '0; cph_ff[i] <= 1'b1;
            ssize_ff[i] <= MAXE; csize_ff[i] <= MAXE;
            isb_ff[i] <= '0; icb_ff[i] <= '0;
         end
      end else if (acc) begin
         unique case (req_data.command)
            CMD_WRITE: begin
               if (req_data.offset == OFF_AQA) begin
                  ssize_ff[0] <= clamp({5'd0, req_data.write_data[11:0]} + 17'd1);
                  csize_ff[0] <= clamp({5'd0, req_data.write_data[27:16]} + 17'd1);
               end else if (db_hit && !db_bad) begin
                  if (db_cq) chead_ff[dbq] <= req_data.write_data[11:0];
                  else stail_ff[dbq] <= req_data.write_data[11:0];
               end
            end
            CMD_CONSUME: begin
               if (chk == ST_OK && shead_ff[q] != stail_ff[q]) shead_ff[q] <= h_nx;
            end
            CMD_POST: begin
               if (chk == ST_OK) begin
                  ctail_ff[q] <= t_nx;
                  if (wrap) cph_ff[q] <= !cph_ff[q];
               end
            end
            CMD_CREATE: begin
               if (qok && q != '0) begin
                  if (req_data.is_completion) begin
                     icb_ff[q] <= req_data.queue_base;
                     csize_ff[q] <= clamp({1'b0, req_data.size_minus_one} + 17'd1);
                  end else begin
                     isb_ff[q] <= req_data.queue_base;
                     ssize_ff[q] <= clamp({1'b0, req_data.size_minus_one} + 17'd1);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff <= '0; rdy_ff <= 1'b0; aqa_ff <= '0; asq_ff <= '0; acq_ff <= '0;
      end else if (acc && req_data.command == CMD_WRITE) begin
         unique case (req_data.offset)
            OFF_CC: begin
               cc_ff <= req_data.write_data;
               rdy_ff <= req_data.write_data[0];
            end
            OFF_AQA:  aqa_ff <= req_data.write_data;
            OFF_ASQL: asq_ff[31:0] <= req_data.write_data;
            OFF_ASQH: asq_ff[63:32] <= req_data.write_data;
            OFF_ACQL: acq_ff[31:0] <= req_data.write_data;
            OFF_ACQH: acq_ff[63:32] <= req_data.write_data;
            default: ;
         endcase
      end
   end

   a_rdy_cc: assert property (@(posedge clock) disable iff (reset) rdy_ff == cc_ff[0])
      else $error("ready flag disagrees with CC.EN");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result lost while stalled");
   a_acc_valid: assert property (@(posedge clock) disable iff (reset) acc |=> rsp_valid_ff)
      else $error("accepted item gave no result");
endmodule
